>>> src/stspg_pkg.sv
// Shared constants and types for the three-axis step pulse generator.
// No dependencies; used by stspg_core and the top level.
`default_nettype none

package stspg_pkg;

    localparam int COORD_WIDTH = 24;
    localparam int COUNT_WIDTH = 32;
    localparam int SPU_WIDTH   = 10;
    localparam int FRAC_BITS   = 8;
    localparam int FRAME_WIDTH = COUNT_WIDTH + 1;
    localparam int NUM_AXES    = 3;
    localparam int PIN_WIDTH   = 2 * NUM_AXES;
    localparam int STAT_WIDTH  = 8;

    // magnitude of a coordinate difference needs one bit more than a coordinate
    localparam int MAG_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH = SPU_WIDTH + MAG_WIDTH;
    localparam int SCL_WIDTH  = PROD_WIDTH - FRAC_BITS;
    localparam int CMP_WIDTH  = (SCL_WIDTH > COUNT_WIDTH) ? SCL_WIDTH : COUNT_WIDTH;

    localparam logic [SPU_WIDTH-1:0] SPU_RESET = SPU_WIDTH'(10);

    // limit switch patterns on the status byte
    localparam logic [STAT_WIDTH-1:0] LIM_X_MASK = 8'b1100_0000;
    localparam logic [STAT_WIDTH-1:0] LIM_Z_MASK = 8'b1010_0000;
    localparam logic [STAT_WIDTH-1:0] LIM_Y_MASK = 8'b0001_0000;

    localparam logic [PIN_WIDTH-1:0] DIR_MASK = 6'b10_1010;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // stream packing
    localparam int IN_BITS    = 2 * NUM_AXES * COORD_WIDTH + STAT_WIDTH;
    localparam int IN_DATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS   = PIN_WIDTH + 3;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [PIN_WIDTH-1:0] port_pins;
        logic                 frame_applied;
        logic                 halted_by_limit;
        logic                 last;
        logic                 busy_res;
    } t_result;

endpackage

`default_nettype wire

>>> src/stspg_core.sv
// Move state and per-item step logic: load math, frame sequencing, limit latch.
// Depends on stspg_pkg.
`default_nettype none

module stspg_core (
    input  wire logic                                                  i_clk,
    input  wire logic                                                  i_rst_n,
    input  wire logic                                                  i_cfg_wr_en,
    input  wire logic [stspg_pkg::SPU_WIDTH-1:0]                       i_cfg_wr_data,
    input  wire logic                                                  i_accept,
    input  wire logic                                                  i_func,
    input  wire logic [stspg_pkg::NUM_AXES-1:0][stspg_pkg::COORD_WIDTH-1:0] i_from,
    input  wire logic [stspg_pkg::NUM_AXES-1:0][stspg_pkg::COORD_WIDTH-1:0] i_to,
    input  wire logic [stspg_pkg::STAT_WIDTH-1:0]                      i_limit_status,
    output stspg_pkg::t_result                                         o_result
);

    localparam int CW  = stspg_pkg::COORD_WIDTH;
    localparam int NW  = stspg_pkg::COUNT_WIDTH;
    localparam int FW  = stspg_pkg::FRAME_WIDTH;
    localparam int NA  = stspg_pkg::NUM_AXES;
    localparam int PW  = stspg_pkg::PIN_WIDTH;
    localparam int MW  = stspg_pkg::MAG_WIDTH;
    localparam int XW  = stspg_pkg::PROD_WIDTH;
    localparam int KW  = stspg_pkg::CMP_WIDTH;

    logic [stspg_pkg::SPU_WIDTH-1:0] r_spu;
    logic [PW-1:0]                   r_pins, n_pins;
    logic [NA-1:0][NW-1:0]           r_count, n_count;
    logic [NA-1:0][NW-1:0]           r_rem, n_rem;
    logic [NW-1:0]                   r_most, n_most;
    logic [FW-1:0]                   r_frame, n_frame;
    logic                            r_latch, n_latch;

    logic [NA-1:0][NW-1:0] ld_count;
    logic [NA-1:0]         ld_up;
    logic [NW-1:0]         ld_most;
    logic [NA-1:0][NW-1:0] rem_nx;
    logic [NA-1:0]         fires;
    logic [PW-1:0]         steps;
    logic [PW-1:0]         ld_pins;
    logic [FW-1:0]         total;
    logic [FW-1:0]         frame_inc;
    logic [NW-1:0]         slot;
    logic                  active;
    logic                  lim_match;
    logic                  applied;
    logic                  last;

    // per-axis count, direction and remainder step
    always_comb begin
        logic signed [MW-1:0] fe;
        logic signed [MW-1:0] te;
        logic [MW-1:0]        mag;
        logic [XW-1:0]        prod;
        logic [KW-1:0]        scaled;
        logic [NW:0]          sum;
        fe = '0;
        te = '0;
        mag = '0;
        prod = '0;
        scaled = '0;
        sum = '0;
        steps = '0;
        ld_pins = '0;
        for (int i = 0; i < NA; i++) begin
            fe = {i_from[i][CW-1], i_from[i]};
            te = {i_to[i][CW-1], i_to[i]};
            ld_up[i] = te > fe;
            mag = ld_up[i] ? MW'(te - fe) : MW'(fe - te);
            prod = XW'(r_spu) * mag;
            scaled = KW'(prod >> stspg_pkg::FRAC_BITS);
            if (scaled > KW'({NW{1'b1}})) begin
                ld_count[i] = {NW{1'b1}};
            end else begin
                ld_count[i] = scaled[NW-1:0];
            end
            ld_pins[2*i+1] = ld_up[i];

            if (r_count[i] == '0) begin
                fires[i] = 1'b0;
            end else if (r_count[i] == NW'(1)) begin
                fires[i] = slot == (r_most >> 1);
            end else begin
                fires[i] = r_rem[i] < r_count[i];
            end
            steps[2*i] = fires[i];

            sum = {1'b0, r_rem[i]} + {1'b0, r_count[i]};
            if (sum >= {1'b0, r_most}) begin
                sum = sum - {1'b0, r_most};
            end
            rem_nx[i] = sum[NW-1:0];
        end
    end

    always_comb begin
        ld_most = ld_count[0];
        for (int i = 1; i < NA; i++) begin
            if (ld_count[i] > ld_most) begin
                ld_most = ld_count[i];
            end
        end
    end

    assign total     = {r_most, 1'b0};
    assign active    = r_frame < total;
    assign frame_inc = r_frame + FW'(1);
    assign slot      = r_frame[FW-1:1];
    assign lim_match = ((i_limit_status & stspg_pkg::LIM_X_MASK) == stspg_pkg::LIM_X_MASK)
                    || ((i_limit_status & stspg_pkg::LIM_Z_MASK) == stspg_pkg::LIM_Z_MASK)
                    || ((i_limit_status & stspg_pkg::LIM_Y_MASK) == stspg_pkg::LIM_Y_MASK);

    always_comb begin
        n_pins  = r_pins;
        n_count = r_count;
        n_rem   = r_rem;
        n_most  = r_most;
        n_frame = r_frame;
        n_latch = r_latch;
        applied = 1'b0;
        last    = 1'b0;
        if (i_func == stspg_pkg::FUNC_LOAD) begin
            n_count = ld_count;
            n_rem   = '0;
            n_most  = ld_most;
            n_pins  = ld_pins;
            n_frame = '0;
            n_latch = 1'b0;
            applied = 1'b1;
        end else if (active) begin
            n_latch = r_latch | lim_match;
            if (!r_frame[0]) begin
                n_rem = rem_nx;
                if (!n_latch) begin
                    n_pins  = (r_pins & stspg_pkg::DIR_MASK) | steps;
                    applied = 1'b1;
                end
            end else if (!n_latch) begin
                n_pins  = r_pins & stspg_pkg::DIR_MASK;
                applied = 1'b1;
            end
            n_frame = frame_inc;
            last    = frame_inc == total;
        end
    end

    assign o_result.port_pins       = n_pins;
    assign o_result.frame_applied   = applied;
    assign o_result.halted_by_limit = n_latch;
    assign o_result.last            = last;
    assign o_result.busy_res        = n_frame < {n_most, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spu   <= stspg_pkg::SPU_RESET;
            r_pins  <= '0;
            r_count <= '0;
            r_rem   <= '0;
            r_most  <= '0;
            r_frame <= '0;
            r_latch <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_spu <= i_cfg_wr_data;
            end
            if (i_accept) begin
                r_pins  <= n_pins;
                r_count <= n_count;
                r_rem   <= n_rem;
                r_most  <= n_most;
                r_frame <= n_frame;
                r_latch <= n_latch;
            end
        end
    end

endmodule

`default_nettype wire

>>> src/three_axis_step_pulse_generator.sv
// Top level: stream ports, field unpacking, result register with skid stage.
// Depends on stspg_pkg and stspg_core.
`default_nettype none

// Three-axis step/direction pulse generator. A transfer with tuser = 0 loads a
// move from a from-point and a to-point (signed, 8 fraction bits); each axis
// gets steps_per_unit * |delta| steps, and the move runs for twice the largest
// count in frames. A transfer with tuser = 1 is one pulse-period tick that
// consumes a frame: even frames raise step pins, odd frames drop them. A limit
// match on the status byte freezes the pins until the next load. Every input
// transfer gives exactly one result transfer. Throughput is one item per clock:
// the step math sits between the input port and a result register, and a skid
// register keeps s_tready high while one result waits; s_tready falls only when
// both the result register and the skid register are full. Each result is
// registered. The user must write steps_per_unit through i_cfg_wr_en /
// i_cfg_wr_data only while no move is pending; the block does not enforce
// this. It applies at the next load.

module three_axis_step_pulse_generator (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_cfg_wr_en,
    input  wire logic [stspg_pkg::SPU_WIDTH-1:0]       i_cfg_wr_data,
    input  wire logic                                  i_s_tvalid,
    output      logic                                  o_s_tready,
    // from_x, from_y, from_z, to_x, to_y, to_z, limit_status (low bits first)
    input  wire logic [stspg_pkg::IN_DATA_W-1:0]       i_s_tdata,
    // func
    input  wire logic                                  i_s_tuser,
    output      logic                                  o_m_tvalid,
    input  wire logic                                  i_m_tready,
    // port_pins, frame_applied, halted_by_limit, busy_res (low bits first)
    output      logic [stspg_pkg::OUT_DATA_W-1:0]      o_m_tdata,
    // last
    output      logic                                  o_m_tlast
);

    localparam int CW = stspg_pkg::COORD_WIDTH;
    localparam int NA = stspg_pkg::NUM_AXES;

    logic [NA-1:0][CW-1:0] w_from;
    logic [NA-1:0][CW-1:0] w_to;
    logic [stspg_pkg::STAT_WIDTH-1:0] w_status;
    stspg_pkg::t_result w_result;
    stspg_pkg::t_result r_out;
    stspg_pkg::t_result r_skid;
    logic r_out_valid;
    logic r_skid_valid;
    logic w_in_xfer;
    logic w_out_xfer;
    logic w_to_out;

    always_comb begin
        for (int i = 0; i < NA; i++) begin
            w_from[i] = i_s_tdata[i*CW +: CW];
            w_to[i]   = i_s_tdata[(NA+i)*CW +: CW];
        end
    end
    assign w_status = i_s_tdata[2*NA*CW +: stspg_pkg::STAT_WIDTH];

    assign o_s_tready = !r_skid_valid;
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = r_out_valid && i_m_tready;
    // new result goes straight to the output register when it is free this cycle
    assign w_to_out   = !r_out_valid || (w_out_xfer && !r_skid_valid);

    stspg_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_accept       (w_in_xfer),
        .i_func         (i_s_tuser),
        .i_from         (w_from),
        .i_to           (w_to),
        .i_limit_status (w_status),
        .o_result       (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (w_out_xfer && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (w_in_xfer && !w_to_out) begin
                r_skid_valid <= 1'b1;
            end
            if (w_in_xfer && w_to_out) begin
                r_out_valid <= 1'b1;
            end else if (w_out_xfer && !r_skid_valid) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_xfer && r_skid_valid) begin
            r_out <= r_skid;
        end
        if (w_in_xfer) begin
            if (w_to_out) begin
                r_out <= w_result;
            end else begin
                r_skid <= w_result;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = stspg_pkg::OUT_DATA_W'({r_out.busy_res, r_out.halted_by_limit,
                                                r_out.frame_applied, r_out.port_pins});

endmodule

`default_nettype wire
